>>> sv/dtpb_pkg.sv
// Package for the depth-to-point back-projection block.
// Holds payload structs, register indexes, reset values and width helpers.
// No dependencies.
`timescale 1ns / 1ps

package dtpb_pkg;

  localparam int MAX_DIM_DEF  = 4096;
  localparam int QUEUE_DEPTH  = 4;
  localparam int FW_W         = 13;
  localparam int CQ4_W        = 16;
  localparam int RECIP_W      = 24;
  localparam int DEPTH_W      = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  localparam logic [DEPTH_W-1:0] NO_DEPTH_CODE = 16'd4096;

  localparam logic [FW_W-1:0]    FRAME_WIDTH_RST = 13'd1280;
  localparam logic [CQ4_W-1:0]   CENTER_X_RST    = 16'd10917;
  localparam logic [CQ4_W-1:0]   CENTER_Y_RST    = 16'd4078;
  localparam logic [RECIP_W-1:0] INV_FX_RST      = 24'd17123;
  localparam logic [RECIP_W-1:0] INV_FY_RST      = 24'd17795;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH = 3'd0,
    REG_CENTER_X    = 3'd1,
    REG_CENTER_Y    = 3'd2,
    REG_INV_FX      = 3'd3,
    REG_INV_FY      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_mm;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic               frame_start;
  } pixel_t;

  typedef struct packed {
    logic               point_valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [DEPTH_W-1:0] pos_z;
    logic [7:0]         out_blue;
    logic [7:0]         out_green;
    logic [7:0]         out_red;
  } point_t;

  // magnitude width of (pos*16 - center_q4)
  function automatic int mag_w(input int max_dim);
    int cw;
    cw = $clog2(max_dim);
    return (cw + 4 > CQ4_W) ? cw + 4 : CQ4_W;
  endfunction

  // queue word: valid, two sign/magnitude pairs, depth, three colour bytes
  function automatic int work_w(input int max_dim);
    return 3 + 2 * mag_w(max_dim) + DEPTH_W + 24;
  endfunction

endpackage

>>> sv/depth_to_point_backprojection.sv
// Top level of the depth-to-point back-projection block: config registers,
// front end, queue and back end. Depends on dtpb_pkg, dtpb_front,
// dtpb_queue and dtpb_back.
//
//   channel | signals                      | direction | payload
//   --------+------------------------------+-----------+-----------------
//   in      | in_valid, in_ready, in_data  | input     | pixel_t
//   out     | out_valid, out_ready, out_data | output  | point_t
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | input | index, 24b
//
// One pixel per cycle while out_ready is high; each result passes from its pixel
// transaction through the queue, two multiplier stages and the output register.
// Synchronous reset clears counters, queue and stage valids; the register
// file returns to its defaults. cfg_ready is always high.
// The 4-entry queue absorbs output stalls; in_ready drops only when it fills.
`timescale 1ns / 1ps

module depth_to_point_backprojection #(
  parameter int MAX_DIM = dtpb_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dtpb_pkg::pixel_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output dtpb_pkg::point_t                    out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dtpb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtpb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dtpb_pkg::*;

  localparam int WW = work_w(MAX_DIM);

  logic [FW_W-1:0]    frame_width;
  logic [CQ4_W-1:0]   center_x_q4, center_y_q4;
  logic [RECIP_W-1:0] inv_focal_x, inv_focal_y;

  logic          push;
  logic [WW-1:0] front_work, q_work;
  logic          q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= FRAME_WIDTH_RST;
      center_x_q4 <= CENTER_X_RST;
      center_y_q4 <= CENTER_Y_RST;
      inv_focal_x <= INV_FX_RST;
      inv_focal_y <= INV_FY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH: frame_width <= cfg_data[FW_W-1:0];
        REG_CENTER_X:    center_x_q4 <= cfg_data[CQ4_W-1:0];
        REG_CENTER_Y:    center_y_q4 <= cfg_data[CQ4_W-1:0];
        REG_INV_FX:      inv_focal_x <= cfg_data[RECIP_W-1:0];
        REG_INV_FY:      inv_focal_y <= cfg_data[RECIP_W-1:0];
        default:         ;
      endcase
    end
  end

  assign push = in_valid && in_ready;

  dtpb_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .pixel       (in_data),
    .frame_width (frame_width),
    .center_x_q4 (center_x_q4),
    .center_y_q4 (center_y_q4),
    .work        (front_work)
  );

  dtpb_queue #(.MAX_DIM(MAX_DIM)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (front_work),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_work)
  );

  dtpb_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_ready    (q_ready),
    .in_work     (q_work),
    .inv_focal_x (inv_focal_x),
    .inv_focal_y (inv_focal_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

`ifndef SYNTHESIS
  // a full queue always has something to offer the back end
  a_full_has_data: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("queue full but empty toward back end");

  // nothing is in flight right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !q_valid && in_ready))
    else $error("pipeline not empty after reset");

  // a valid point never carries a no-depth code
  a_valid_depth: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.point_valid) |->
      (out_data.pos_z != '0 && out_data.pos_z != NO_DEPTH_CODE))
    else $error("valid point with unusable depth");

  // invalid points come out with zeroed coordinates
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.point_valid) |->
      (out_data.pos_x == 0 && out_data.pos_y == 0 && out_data.pos_z == '0))
    else $error("invalid point with nonzero coordinates");
`endif

endmodule

>>> sv/dtpb_front.sv
// Front end: pixel position counters, depth check and centered offsets.
// Depends on dtpb_pkg.
`timescale 1ns / 1ps

module dtpb_front #(
  parameter int MAX_DIM = dtpb_pkg::MAX_DIM_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  input  dtpb_pkg::pixel_t                        pixel,
  input  logic [dtpb_pkg::FW_W-1:0]               frame_width,
  input  logic [dtpb_pkg::CQ4_W-1:0]              center_x_q4,
  input  logic [dtpb_pkg::CQ4_W-1:0]              center_y_q4,
  output logic [dtpb_pkg::work_w(MAX_DIM)-1:0]    work
);
  import dtpb_pkg::*;

  localparam int CW = $clog2(MAX_DIM);
  localparam int MW = mag_w(MAX_DIM);
  localparam int DW = MW + 1;
  localparam int EW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

  logic [CW-1:0] col, col_next;
  logic [CW-1:0] row, row_next;
  logic [CW-1:0] cur_col, cur_row;
  logic [EW-1:0] eff_width;
  logic [EW-1:0] col_inc;
  logic          depth_ok;
  logic [DW-1:0] diff_x, diff_y;
  logic [MW-1:0] mag_x, mag_y;
  logic [DEPTH_W-1:0] depth_used;

  always_comb begin
    cur_col = pixel.frame_start ? '0 : col;
    cur_row = pixel.frame_start ? '0 : row;

    if (frame_width == '0) begin
      eff_width = EW'(1);
    end else if (EW'(frame_width) > EW'(MAX_DIM)) begin
      eff_width = EW'(MAX_DIM);
    end else begin
      eff_width = EW'(frame_width);
    end

    col_inc  = EW'(cur_col) + EW'(1);
    col_next = cur_col;
    row_next = cur_row;
    if (col_inc >= eff_width) begin
      col_next = '0;
      if (cur_row < CW'(MAX_DIM - 1)) begin
        row_next = cur_row + CW'(1);
      end
    end else begin
      col_next = col_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (push) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // both operands stay below 2^(DW-1), so the difference fits signed DW
  always_comb begin
    depth_ok   = (pixel.depth_mm != '0) && (pixel.depth_mm != NO_DEPTH_CODE);
    depth_used = depth_ok ? pixel.depth_mm : '0;
    diff_x     = DW'({cur_col, 4'b0000}) - DW'(center_x_q4);
    diff_y     = DW'({cur_row, 4'b0000}) - DW'(center_y_q4);
    mag_x      = diff_x[DW-1] ? MW'(-diff_x) : diff_x[MW-1:0];
    mag_y      = diff_y[DW-1] ? MW'(-diff_y) : diff_y[MW-1:0];
  end

  assign work = {depth_ok, diff_x[DW-1], mag_x, diff_y[DW-1], mag_y, depth_used,
                 pixel.blue, pixel.green, pixel.red};

endmodule

>>> sv/dtpb_queue.sv
// Small register FIFO between the front end and the projection back end.
// Depends on dtpb_pkg.
`timescale 1ns / 1ps

module dtpb_queue #(
  parameter int MAX_DIM = dtpb_pkg::MAX_DIM_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_valid,
  output logic                                 wr_ready,
  input  logic [dtpb_pkg::work_w(MAX_DIM)-1:0] wr_data,
  output logic                                 rd_valid,
  input  logic                                 rd_ready,
  output logic [dtpb_pkg::work_w(MAX_DIM)-1:0] rd_data
);
  import dtpb_pkg::*;

  localparam int WW = work_w(MAX_DIM);
  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [WW-1:0] entries [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_wr, do_rd;

  assign wr_ready = (count != (AW+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/dtpb_back.sv
// Back end: two multiplier stages, then floor rounding and saturation.
// Depends on dtpb_pkg.
`timescale 1ns / 1ps

module dtpb_back #(
  parameter int MAX_DIM = dtpb_pkg::MAX_DIM_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dtpb_pkg::work_w(MAX_DIM)-1:0] in_work,
  input  logic [dtpb_pkg::RECIP_W-1:0]         inv_focal_x,
  input  logic [dtpb_pkg::RECIP_W-1:0]         inv_focal_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output dtpb_pkg::point_t                     out_data
);
  import dtpb_pkg::*;

  localparam int MW = mag_w(MAX_DIM);
  localparam int M1 = MW + DEPTH_W;
  localparam int PW = M1 + RECIP_W;
  localparam int QW = PW - 23;

  logic               w_ok, w_sx, w_sy;
  logic [MW-1:0]      w_mx, w_my;
  logic [DEPTH_W-1:0] w_depth;
  logic [23:0]        w_bgr;

  assign {w_ok, w_sx, w_mx, w_sy, w_my, w_depth, w_bgr} = in_work;

  // stage 1: offset times depth
  logic               s1_v, s1_ok, s1_sx, s1_sy;
  logic [M1-1:0]      s1_mx, s1_my;
  logic [DEPTH_W-1:0] s1_depth;
  logic [23:0]        s1_bgr;
  // stage 2: times reciprocal focal length
  logic               s2_v, s2_ok, s2_sx, s2_sy;
  logic [PW-1:0]      s2_px, s2_py;
  logic [DEPTH_W-1:0] s2_depth;
  logic [23:0]        s2_bgr;

  logic en1, en2, en3;

  assign en3      = !out_valid || out_ready;
  assign en2      = !s2_v || en3;
  assign en1      = !s1_v || en2;
  assign in_ready = en1;

  // floor(+-p / 2^24) saturated to signed 32 bits
  function automatic logic [31:0] round_sat(input logic neg, input logic [PW-1:0] p);
    logic [PW:0]   sum;
    logic [QW-1:0] q;
    logic [31:0]   res;
    if (neg) begin
      sum = {1'b0, p} + (PW+1)'(24'hFFFFFF);
      q   = sum[PW:24];
      res = (q > QW'(64'h8000_0000)) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end else begin
      q   = QW'(p[PW-1:24]);
      res = (q > QW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) s1_v      <= in_valid;
      if (en2) s2_v      <= s1_v;
      if (en3) out_valid <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ok    <= w_ok;
      s1_sx    <= w_sx;
      s1_sy    <= w_sy;
      s1_mx    <= M1'(w_mx) * M1'(w_depth);
      s1_my    <= M1'(w_my) * M1'(w_depth);
      s1_depth <= w_depth;
      s1_bgr   <= w_bgr;
    end
    if (en2) begin
      s2_ok    <= s1_ok;
      s2_sx    <= s1_sx;
      s2_sy    <= s1_sy;
      s2_px    <= PW'(s1_mx) * PW'(inv_focal_x);
      s2_py    <= PW'(s1_my) * PW'(inv_focal_y);
      s2_depth <= s1_depth;
      s2_bgr   <= s1_bgr;
    end
    if (en3) begin
      // invalid depth was zeroed up front, so the coordinates come out 0
      out_data.point_valid <= s2_ok;
      out_data.pos_x       <= round_sat(s2_sx, s2_px);
      out_data.pos_y       <= round_sat(s2_sy, s2_py);
      out_data.pos_z       <= s2_depth;
      out_data.out_blue    <= s2_bgr[23:16];
      out_data.out_green   <= s2_bgr[15:8];
      out_data.out_red     <= s2_bgr[7:0];
    end
  end

endmodule
